@@ rtl/sonar_sweep_ranger_assert.svh @@
// assertion macros for the sonar sweep ranger
`ifndef SONAR_SWEEP_RANGER_ASSERT_SVH
`define SONAR_SWEEP_RANGER_ASSERT_SVH

// same-cycle implication
`define SSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ssr_pkg.sv @@
`default_nettype none

package ssr_pkg;

	localparam int ANGLE_W = 8;
	localparam int STEP_W  = 5;
	localparam int DIST_W  = 11;
	localparam int ECHO_W  = 16;
	localparam int PTICK_W = 4;
	localparam int PROD_W  = 27;
	localparam int DIST_SHIFT = 16;
	localparam logic [PROD_W-1:0] DIST_MUL = 27'd1124;

	typedef enum logic [1:0] {
		REG_SWEEP_LO   = 2'd0,
		REG_SWEEP_HI   = 2'd1,
		REG_STEP_ANGLE = 2'd2,
		REG_LOCK_SWEEP = 2'd3
	} ssr_reg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] sweep_lo;
		logic [ANGLE_W-1:0] sweep_hi;
		logic [STEP_W-1:0]  step_angle;
		logic               lock_sweep;
	} ssr_cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               down;
	} ssr_move_t;

	typedef struct packed {
		logic sample_start;
		logic echo_level;
	} ssr_in_t;

	typedef struct packed {
		logic               trig_level;
		logic [ANGLE_W-1:0] servo_angle;
		logic [DIST_W-1:0]  distance_cm;
		logic               measure_done;
		logic               timed_out;
		logic               busy_res;
	} ssr_out_t;

endpackage

`default_nettype wire

@@ rtl/sonar_sweep_ranger.sv @@
// channel  | direction | payload            | handshake
// sample   | in        | ssr_in_t           | sample_valid / sample_ready
// result   | out       | ssr_out_t          | result_valid / result_ready
// cfg      | in        | cfg_index, cfg_data | cfg_valid / cfg_ready
//
// one tick per cycle while sample_ready is high: each sample transaction updates the sequencer and
// writes one result into the output register in the same cycle
// sample_ready is held low only while a result waits and result_ready is low
// arst_n clears sequencer, sweep state, stored distance and output valid; cfg regs go to reset values
// cfg writes are always taken
`default_nettype none
`include "sonar_sweep_ranger_assert.svh"

module sonar_sweep_ranger #(
	parameter int ECHO_TIMEOUT    = 60000,
	parameter int TRIG_HIGH_TICKS = 10,
	parameter int TRIG_LOW_TICKS  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  ssr_pkg::ssr_in_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output ssr_pkg::ssr_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ssr_pkg::ssr_reg_t cfg_index,
	input  logic [7:0]        cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TLOW  = 3'd1,
		PH_THIGH = 3'd2,
		PH_WAIT  = 3'd3,
		PH_COUNT = 3'd4
	} phase_t;

	localparam logic [ssr_pkg::ECHO_W-1:0]  TimeoutLim = ssr_pkg::ECHO_W'(ECHO_TIMEOUT);
	localparam logic [ssr_pkg::PTICK_W-1:0] HighLim    = ssr_pkg::PTICK_W'(TRIG_HIGH_TICKS);
	localparam logic [ssr_pkg::PTICK_W-1:0] LowLim     = ssr_pkg::PTICK_W'(TRIG_LOW_TICKS);

	ssr_pkg::ssr_cfg_t cfg_q;

	phase_t                        phase_q,  phase_d;
	logic [ssr_pkg::PTICK_W-1:0]   ticks_q,  ticks_d;
	logic [ssr_pkg::ECHO_W-1:0]    echo_q,   echo_d;
	logic [ssr_pkg::DIST_W-1:0]    dist_q,   dist_d;
	logic                          tout_q,   tout_d;
	logic [ssr_pkg::ANGLE_W-1:0]   angle_q,  angle_d;
	logic                          down_q,   down_d;
	logic [ssr_pkg::PROD_W-1:0]    prod;
	logic                          trig;
	logic                          done;
	logic                          fin;
	logic                          fin_tout;
	logic                          accept;
	logic                          out_valid_q;
	ssr_pkg::ssr_out_t             result_q;
	ssr_pkg::ssr_move_t            move;
	logic                          out_done;
	logic                          out_trig;
	logic [ssr_pkg::ANGLE_W-1:0]   out_angle;
	logic                          thigh_acc;
	logic                          lock_acc;

	ssr_sweep u_sweep (
		.cfg   (cfg_q),
		.angle (angle_q),
		.down  (down_q),
		.move  (move)
	);

	assign cfg_ready    = 1'b1;
	assign sample_ready = !out_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_comb begin
		phase_d  = phase_q;
		ticks_d  = ticks_q;
		echo_d   = echo_q;
		dist_d   = dist_q;
		tout_d   = tout_q;
		angle_d  = angle_q;
		down_d   = down_q;
		trig     = 1'b0;
		done     = 1'b0;
		fin      = 1'b0;
		fin_tout = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (sample.sample_start) begin
					if (!cfg_q.lock_sweep) begin
						angle_d = move.angle;
						down_d  = move.down;
					end
					phase_d = PH_TLOW;
					ticks_d = '0;
				end
			end
			PH_TLOW: begin
			end
			PH_THIGH: begin
				trig    = 1'b1;
				ticks_d = ticks_q + 1'b1;
				if (ticks_d >= HighLim) begin
					phase_d = PH_WAIT;
					ticks_d = '0;
				end
			end
			PH_WAIT: begin
				if (sample.echo_level) begin
					echo_d  = ssr_pkg::ECHO_W'(1);
					phase_d = PH_COUNT;
					if (echo_d > TimeoutLim) begin
						fin      = 1'b1;
						fin_tout = 1'b1;
					end
				end
			end
			PH_COUNT: begin
				if (sample.echo_level) begin
					echo_d = echo_q + 1'b1;
					if (echo_d > TimeoutLim) begin
						fin      = 1'b1;
						fin_tout = 1'b1;
					end
				end else begin
					fin = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				ticks_d = '0;
			end
		endcase
		// distance = count * 1124 >> 16
		prod = ssr_pkg::PROD_W'(echo_d) * ssr_pkg::DIST_MUL;
		if (fin) begin
			phase_d = PH_IDLE;
			ticks_d = '0;
			tout_d  = fin_tout;
			dist_d  = prod[ssr_pkg::DIST_SHIFT +: ssr_pkg::DIST_W];
			done    = 1'b1;
		end
		// trigger low phase, start tick counts as the first
		if (phase_d == PH_TLOW) begin
			ticks_d = ticks_d + 1'b1;
			if (ticks_d >= LowLim) begin
				phase_d = PH_THIGH;
				ticks_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_lo   <= '0;
			cfg_q.sweep_hi   <= ssr_pkg::ANGLE_W'(180);
			cfg_q.step_angle <= ssr_pkg::STEP_W'(10);
			cfg_q.lock_sweep <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssr_pkg::REG_SWEEP_LO:   cfg_q.sweep_lo   <= cfg_data;
				ssr_pkg::REG_SWEEP_HI:   cfg_q.sweep_hi   <= cfg_data;
				ssr_pkg::REG_STEP_ANGLE: cfg_q.step_angle <= cfg_data[ssr_pkg::STEP_W-1:0];
				ssr_pkg::REG_LOCK_SWEEP: cfg_q.lock_sweep <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ticks_q     <= '0;
			echo_q      <= '0;
			dist_q      <= '0;
			tout_q      <= 1'b0;
			angle_q     <= '0;
			down_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			ticks_q     <= ticks_d;
			echo_q      <= echo_d;
			dist_q      <= dist_d;
			tout_q      <= tout_d;
			angle_q     <= angle_d;
			down_q      <= down_d;
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.trig_level   <= trig;
			result_q.servo_angle  <= angle_d;
			result_q.distance_cm  <= dist_d;
			result_q.measure_done <= done;
			result_q.timed_out    <= tout_d;
			result_q.busy_res     <= (phase_d != PH_IDLE);
		end
	end

	assign out_done  = result_valid && result.measure_done;
	assign out_trig  = result_valid && result.trig_level;
	assign out_angle = result.servo_angle;
	assign thigh_acc = accept && (phase_q == PH_THIGH);
	assign lock_acc  = accept && cfg_q.lock_sweep;

	`SSR_ASSERT_IMP(a_done_idle, clk, arst_n, out_done, !result.busy_res, "done while busy")
	`SSR_ASSERT_IMP(a_trig_busy, clk, arst_n, out_trig, result.busy_res, "trigger high while idle")
	`SSR_ASSERT_NXT(a_thigh_trig, clk, arst_n, thigh_acc, out_trig, "trigger phase lost")
	`SSR_ASSERT_NXT(a_lock_hold, clk, arst_n, lock_acc, out_angle == $past(angle_q), "angle moved")

endmodule

`default_nettype wire

@@ rtl/ssr_sweep.sv @@
`default_nettype none

module ssr_sweep (
	input  ssr_pkg::ssr_cfg_t          cfg,
	input  logic [ssr_pkg::ANGLE_W-1:0] angle,
	input  logic                       down,
	output ssr_pkg::ssr_move_t         move
);

	logic [ssr_pkg::ANGLE_W:0] sum;
	logic [ssr_pkg::ANGLE_W:0] diff;
	logic [ssr_pkg::ANGLE_W:0] step_x;
	logic [ssr_pkg::ANGLE_W:0] max_x;
	logic [ssr_pkg::ANGLE_W:0] min_x;
	logic [ssr_pkg::ANGLE_W:0] v;
	logic                      a_ge_s;
	logic                      nd;

	assign step_x = (ssr_pkg::ANGLE_W+1)'(cfg.step_angle);
	assign max_x  = {1'b0, cfg.sweep_hi};
	assign min_x  = {1'b0, cfg.sweep_lo};
	assign sum    = {1'b0, angle} + step_x;
	assign diff   = {1'b0, angle} - step_x;
	assign a_ge_s = {1'b0, angle} >= step_x;

	always_comb begin
		if (!down) begin
			if (sum < max_x) begin
				v  = sum;
				nd = 1'b0;
			end else begin
				v  = a_ge_s ? diff : '0;
				nd = 1'b1;
			end
		end else begin
			if (a_ge_s && (diff > min_x)) begin
				v  = diff;
				nd = 1'b1;
			end else begin
				v  = sum;
				nd = 1'b0;
			end
		end
		// clamp to bounds, lower bound wins
		if (v > max_x) begin
			v = max_x;
		end
		if (v < min_x) begin
			v = min_x;
		end
		move.angle = v[ssr_pkg::ANGLE_W-1:0];
		move.down  = nd;
	end

endmodule

`default_nettype wire
